// ===== hdl/lpht_pkg.sv =====
// ---------------------------------------------------------------------------
// lpht_pkg
// Shared codes and fixed field widths for the linear probing hash table.
// ---------------------------------------------------------------------------
package lpht_pkg;

  localparam int OP_W     = 3;
  localparam int HASH_W   = 64;
  localparam int SIDX_W   = 10;
  localparam int STATUS_W = 2;
  localparam int LIVE_W   = 11;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_FIND   = 3'd1,
    OP_REMOVE = 3'd2,
    OP_ERASE  = 3'd3,
    OP_SET    = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_MISS   = 2'd1,
    STATUS_EXISTS = 2'd2,
    STATUS_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FLAG_EMPTY   = 2'd0,
    FLAG_DELETED = 2'd1,
    FLAG_USED    = 2'd2
  } flag_t;

endpackage

// ===== hdl/linear_probe_hash_table_core.sv =====
// ---------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open addressing hash table with linear probing and tombstones.
// ---------------------------------------------------------------------------
//  channel  | signals                                        | direction
//  ---------+------------------------------------------------+----------
//  request  | in_valid, in_stall, op, key, value, key_hash,  | in
//           | slot_index                                     |
//  response | out_valid, out_stall, status, found_value,     | out
//           | result_slot, live_count                        |
//
//  After a transfer the core runs its probes and then registers the response; the
//  next transfer is taken only once the response is issued. Each probe is one read
//  and one check. Erase and set value take one probe; a full-table insert, unknown
//  op or out-of-range slot_index takes none. With SLOTS not a power of two the hash
//  is reduced four bits a cycle first. After reset the flag memory is swept to empty.
//  One held response does not block the next transfer; a second one waits for it.
// ---------------------------------------------------------------------------
module linear_probe_hash_table_core
  import lpht_pkg::*;
#(
  parameter int SLOTS      = 1024,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       op,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [HASH_W-1:0]     key_hash,
  input  logic [SIDX_W-1:0]     slot_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   status,
  output logic [VALUE_BITS-1:0] found_value,
  output logic [SIDX_W-1:0]     result_slot,
  output logic [LIVE_W-1:0]     live_count
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam bit POW2  = (SLOTS & (SLOTS - 1)) == 0;
  localparam logic [IDX_W:0]   SLOTS_X  = (IDX_W + 1)'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] LAST_PRB = CNT_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);
  localparam int MOD_STEPS = HASH_W / 4;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_HASH  = 6'b000100,
    ST_READ  = 6'b001000,
    ST_CHECK = 6'b010000,
    ST_RESP  = 6'b100000
  } state_t;

  state_t state;

  op_t                   op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [HASH_W-1:0]     hash_r;
  logic [IDX_W-1:0]      pos;
  logic [CNT_W-1:0]      probe_n;
  logic [CNT_W-1:0]      count;
  logic [$clog2(MOD_STEPS)-1:0] mod_n;

  status_t               res_status;
  logic [VALUE_BITS-1:0] res_fval;
  logic [IDX_W-1:0]      res_slot;

  logic [1:0]            flag_mem [SLOTS];
  logic [HASH_W-1:0]     hash_mem [SLOTS];
  logic [KEY_BITS-1:0]   key_mem  [SLOTS];
  logic [VALUE_BITS-1:0] val_mem  [SLOTS];

  logic [1:0]            rd_flag;
  logic [HASH_W-1:0]     rd_hash;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;

  logic       flag_we;
  logic [1:0] flag_wd;
  logic       hk_we;
  logic       val_we;
  logic       cnt_up;
  logic       cnt_dn;
  logic       chk_done;
  logic       chk_hit;
  logic       chk_give_val;
  status_t    chk_status;
  logic       match;
  logic       last_probe;
  logic [IDX_W-1:0] pos_inc;
  logic [IDX_W-1:0] rem_next;
  logic       in_xfer;

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // Remainder step: four restoring compare-subtract steps per cycle
  always_comb begin
    logic [IDX_W:0] t;
    t = {1'b0, pos};
    for (int i = 0; i < 4; i++) begin
      t = {t[IDX_W-1:0], hash_r[HASH_W-1-i]};
      if (t >= SLOTS_X) begin
        t = t - SLOTS_X;
      end
    end
    rem_next = t[IDX_W-1:0];
  end

  assign pos_inc    = (pos == LAST_IDX) ? '0 : pos + 1'b1;
  assign match      = (rd_hash == hash_r) && (rd_key == key_r);
  assign last_probe = (probe_n == LAST_PRB);

  always_comb begin
    chk_done     = 1'b0;
    chk_hit      = 1'b0;
    chk_give_val = 1'b0;
    chk_status   = STATUS_FULL;
    flag_we      = 1'b0;
    flag_wd      = FLAG_EMPTY;
    hk_we        = 1'b0;
    val_we       = 1'b0;
    cnt_up       = 1'b0;
    cnt_dn       = 1'b0;
    if (state == ST_CLEAR) begin
      flag_we = 1'b1;
    end else if (state == ST_CHECK) begin
      case (op_r) inside
        OP_INSERT: begin
          if (rd_flag != FLAG_USED) begin
            chk_done   = 1'b1;
            chk_hit    = 1'b1;
            chk_status = STATUS_OK;
            flag_we    = 1'b1;
            flag_wd    = FLAG_USED;
            hk_we      = 1'b1;
            val_we     = 1'b1;
            cnt_up     = 1'b1;
          end else if (match) begin
            chk_done   = 1'b1;
            chk_status = STATUS_EXISTS;
          end else if (last_probe) begin
            chk_done   = 1'b1;
            chk_status = STATUS_FULL;
          end
        end
        OP_FIND, OP_REMOVE: begin
          if (rd_flag == FLAG_EMPTY) begin
            chk_done   = 1'b1;
            chk_status = STATUS_MISS;
          end else if (match) begin
            chk_done = 1'b1;
            if (rd_flag == FLAG_DELETED) begin
              chk_status = STATUS_MISS;
            end else begin
              chk_status   = STATUS_OK;
              chk_hit      = 1'b1;
              chk_give_val = 1'b1;
              if (op_r == OP_REMOVE) begin
                flag_we = 1'b1;
                flag_wd = FLAG_DELETED;
                cnt_dn  = 1'b1;
              end
            end
          end else if (last_probe) begin
            chk_done   = 1'b1;
            chk_status = STATUS_MISS;
          end
        end
        OP_ERASE, OP_SET: begin
          chk_done = 1'b1;
          if (rd_flag != FLAG_USED) begin
            chk_status = STATUS_MISS;
          end else begin
            chk_status = STATUS_OK;
            chk_hit    = 1'b1;
            if (op_r == OP_ERASE) begin
              chk_give_val = 1'b1;
              flag_we      = 1'b1;
              flag_wd      = FLAG_DELETED;
              cnt_dn       = 1'b1;
            end else begin
              val_we = 1'b1;
            end
          end
        end
        default: begin
          chk_done   = 1'b1;
          chk_status = STATUS_FULL;
        end
      endcase
    end
  end

  // Slot memories: one write and one registered read, both at pos
  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[pos] <= flag_wd;
    end
    if (hk_we) begin
      hash_mem[pos] <= hash_r;
      key_mem[pos]  <= key_r;
    end
    if (val_we) begin
      val_mem[pos] <= value_r;
    end
    if (state == ST_READ) begin
      rd_flag <= flag_mem[pos];
      rd_hash <= hash_mem[pos];
      rd_key  <= key_mem[pos];
      rd_val  <= val_mem[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      pos       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_RESP) begin
        out_valid <= 1'b0;
      end
      if (cnt_up) begin
        count <= count + 1'b1;
      end else if (cnt_dn) begin
        count <= count - 1'b1;
      end
      unique case (state)
        ST_CLEAR: begin
          pos <= pos_inc;
          if (pos == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            op_r       <= op_t'(op);
            key_r      <= key;
            value_r    <= value;
            hash_r     <= key_hash;
            probe_n    <= '0;
            mod_n      <= '0;
            res_status <= STATUS_FULL;
            res_fval   <= '0;
            res_slot   <= '0;
            case (op) inside
              OP_INSERT, OP_FIND, OP_REMOVE: begin
                if (op == OP_INSERT && count >= FULL_CNT) begin
                  state <= ST_RESP;
                end else if (POW2) begin
                  pos   <= key_hash[IDX_W-1:0];
                  state <= ST_READ;
                end else begin
                  pos   <= '0;
                  state <= ST_HASH;
                end
              end
              OP_ERASE, OP_SET: begin
                if (32'(slot_index) < SLOTS) begin
                  pos   <= IDX_W'(slot_index);
                  state <= ST_READ;
                end else begin
                  state <= ST_RESP;
                end
              end
              default: state <= ST_RESP;
            endcase
          end
        end
        ST_HASH: begin
          pos    <= rem_next;
          hash_r <= {hash_r[HASH_W-5:0], hash_r[HASH_W-1:HASH_W-4]};
          mod_n  <= mod_n + 1'b1;
          if (mod_n == ($clog2(MOD_STEPS))'(MOD_STEPS - 1)) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (chk_done) begin
            res_status <= chk_status;
            if (chk_hit) begin
              res_slot <= pos;
            end
            if (chk_give_val) begin
              res_fval <= rd_val;
            end
            state <= ST_RESP;
          end else begin
            pos     <= pos_inc;
            probe_n <= probe_n + 1'b1;
            state   <= ST_READ;
          end
        end
        ST_RESP: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            found_value <= res_fval;
            result_slot <= SIDX_W'(res_slot);
            live_count  <= LIVE_W'(cnt_up ? count + 1'b1 : count);
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count above table size");

  a_count_only_on_check: assert property (@(posedge clk) disable iff (rst)
    (state != ST_CHECK) |=> $stable(count))
    else $error("entry count changed outside a slot check");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_OK) |-> (result_slot == '0 && found_value == '0))
    else $error("failed request returned slot or value");

  a_xfer_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state != ST_IDLE))
    else $error("request transfer did not start work");

endmodule

// ===== dv/linear_probe_hash_table_core_test.sv =====
// ---------------------------------------------------------------------------
// linear_probe_hash_table_core_test
// Self-checking bench for the linear probing hash table core. A shadow copy
// of the table predicts the response of every request transfer; responses
// are checked in order. Directed requests cover field extremes, probe
// wrap-around, tombstone reuse and duplicate keys. A random phase with a small
// pool of live keys follows, then the table is filled to capacity to hit the
// full-table and exhausted-probe cases.
// ---------------------------------------------------------------------------
module linear_probe_hash_table_core_test;
  import lpht_pkg::*;

  localparam int SLOTS         = 1024;
  localparam int POOL_DEPTH    = 64;
  localparam int RANDOM_ITEMS  = 700;
  localparam int MAX_REPORTS   = 10;
  localparam int HOLD_AT       = 560;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 64;
  localparam int CYCLE_LIMIT   = 20_000_000;

  typedef struct {
    status_t          status;
    logic [63:0]      found_value;
    logic [SIDX_W-1:0] result_slot;
    logic [LIVE_W-1:0] live_count;
  } response_t;

  class hash_table_shadow;
    flag_t       flags  [SLOTS];
    logic [63:0] hashes [SLOTS];
    logic [63:0] keys   [SLOTS];
    logic [63:0] vals   [SLOTS];
    int unsigned count;
    response_t   due_responses[$];
    int          errors;
    int          responses;

    function new();
      foreach (flags[i]) begin
        flags[i]  = FLAG_EMPTY;
        hashes[i] = '0;
        keys[i]   = '0;
        vals[i]   = '0;
      end
      count     = 0;
      errors    = 0;
      responses = 0;
    endfunction

    function int locate(input logic [63:0] k, input logic [63:0] h);
      int unsigned pos;
      pos = 32'(h % SLOTS);
      for (int n = 0; n < SLOTS; n++) begin
        if (flags[pos] == FLAG_EMPTY) return -1;
        if (hashes[pos] == h && keys[pos] == k)
          return (flags[pos] == FLAG_DELETED) ? -1 : int'(pos);
        pos = (pos + 1) % SLOTS;
      end
      return -1;
    endfunction

    function void apply_request(input logic [OP_W-1:0] opc, input logic [63:0] k,
                                input logic [63:0] v, input logic [63:0] h,
                                input logic [SIDX_W-1:0] sidx);
      response_t   r;
      int unsigned pos;
      int          hit;
      r.status      = STATUS_FULL;
      r.found_value = '0;
      r.result_slot = '0;
      case (opc)
        OP_INSERT: begin
          if (count < SLOTS) begin
            pos = 32'(h % SLOTS);
            for (int n = 0; n < SLOTS; n++) begin
              if (flags[pos] != FLAG_USED) begin
                flags[pos]    = FLAG_USED;
                keys[pos]     = k;
                vals[pos]     = v;
                hashes[pos]   = h;
                count++;
                r.status      = STATUS_OK;
                r.result_slot = SIDX_W'(pos);
                break;
              end
              if (hashes[pos] == h && keys[pos] == k) begin
                r.status = STATUS_EXISTS;
                break;
              end
              pos = (pos + 1) % SLOTS;
            end
          end
        end
        OP_FIND, OP_REMOVE: begin
          hit = locate(k, h);
          if (hit < 0) begin
            r.status = STATUS_MISS;
          end else begin
            r.status      = STATUS_OK;
            r.found_value = vals[hit];
            r.result_slot = SIDX_W'(hit);
            if (opc == OP_REMOVE) begin
              flags[hit] = FLAG_DELETED;
              count--;
            end
          end
        end
        OP_ERASE, OP_SET: begin
          if (sidx < SLOTS) begin
            if (flags[sidx] != FLAG_USED) begin
              r.status = STATUS_MISS;
            end else if (opc == OP_ERASE) begin
              flags[sidx]   = FLAG_DELETED;
              count--;
              r.status      = STATUS_OK;
              r.found_value = vals[sidx];
              r.result_slot = sidx;
            end else begin
              vals[sidx]    = v;
              r.status      = STATUS_OK;
              r.result_slot = sidx;
            end
          end
        end
        default: ;
      endcase
      r.live_count = LIVE_W'(count);
      due_responses.push_back(r);
    endfunction

    function void check_response(input logic [STATUS_W-1:0] st, input logic [63:0] fv,
                                 input logic [SIDX_W-1:0] rs, input logic [LIVE_W-1:0] lc);
      response_t e;
      responses++;
      if (due_responses.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected response: status=%0d value=%h slot=%0d live=%0d",
                   st, fv, rs, lc);
        return;
      end
      e = due_responses.pop_front();
      if (st !== e.status || fv !== e.found_value || rs !== e.result_slot ||
          lc !== e.live_count) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("response %0d mismatch: status %0d/%0d value %h/%h slot %0d/%0d live %0d/%0d",
                   responses, e.status, st, e.found_value, fv, e.result_slot, rs,
                   e.live_count, lc);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [OP_W-1:0]     op;
  logic [63:0]         key;
  logic [63:0]         value;
  logic [HASH_W-1:0]   key_hash;
  logic [SIDX_W-1:0]   slot_index;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] status;
  logic [63:0]         found_value;
  logic [SIDX_W-1:0]   result_slot;
  logic [LIVE_W-1:0]   live_count;

  hash_table_shadow board;
  logic [63:0]      known_keys[$];
  logic [63:0]      known_hashes[$];
  int               tx_idle_pct;
  int               rx_idle_pct;
  int               hold_left;
  bit               hold_done;
  int               cycles;

  linear_probe_hash_table_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .key         (key),
    .value       (value),
    .key_hash    (key_hash),
    .slot_index  (slot_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_value (found_value),
    .result_slot (result_slot),
    .live_count  (live_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_response(status, found_value, result_slot, live_count);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && board.responses == HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_request(input logic [OP_W-1:0] opc, input logic [63:0] k,
                              input logic [63:0] v, input logic [63:0] h,
                              input logic [SIDX_W-1:0] sidx);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid   <= 1'b1;
    op         <= opc;
    key        <= k;
    value      <= v;
    key_hash   <= h;
    slot_index <= sidx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.apply_request(opc, k, v, h, sidx);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Most hashes land in a window that wraps past the last slot.
  function automatic logic [63:0] fresh_hash();
    logic [63:0] h;
    h = rand64();
    if ($urandom_range(9) != 0) h[9:0] = 10'((900 + $urandom_range(0, 255)) % SLOTS);
    return h;
  endfunction

  function automatic void remember(input logic [63:0] k, input logic [63:0] h);
    int idx;
    if (known_keys.size() < POOL_DEPTH) begin
      known_keys.push_back(k);
      known_hashes.push_back(h);
    end else begin
      idx = $urandom_range(POOL_DEPTH - 1);
      known_keys[idx]   = k;
      known_hashes[idx] = h;
    end
  endfunction

  task automatic directed_requests();
    logic [63:0] ones;
    logic [63:0] v;
    ones = '1;
    v    = rand64();
    send_request(OP_FIND,   '0,   rand64(), '0,        10'd0);
    send_request(OP_INSERT, '0,   '0,       '0,        10'd0);
    send_request(OP_INSERT, ones, ones,     ones,      10'd1023);
    send_request(OP_INSERT, 64'd5, rand64(), 64'h3ff,  10'd0);
    send_request(OP_INSERT, ones, rand64(), ones,      10'd0);
    send_request(OP_FIND,   64'd5, rand64(), 64'h3ff,  10'd0);
    // tombstone ahead of an existing key lets the key be stored twice
    send_request(OP_INSERT, 64'd100, rand64(), 64'd512, 10'd0);
    send_request(OP_INSERT, 64'd101, rand64(), 64'd512, 10'd0);
    send_request(OP_INSERT, 64'd102, rand64(), 64'd512, 10'd0);
    send_request(OP_REMOVE, 64'd101, rand64(), 64'd512, 10'd0);
    send_request(OP_INSERT, 64'd102, rand64(), 64'd512, 10'd0);
    send_request(OP_FIND,   64'd102, rand64(), 64'd512, 10'd0);
    // a deleted slot that matches ends the walk with a miss
    send_request(OP_REMOVE, 64'd100, rand64(), 64'd512, 10'd0);
    send_request(OP_FIND,   64'd100, rand64(), 64'd512, 10'd0);
    send_request(OP_ERASE,  rand64(), rand64(), rand64(), 10'd512);
    send_request(OP_ERASE,  rand64(), rand64(), rand64(), 10'd700);
    send_request(OP_SET,    rand64(), rand64(), rand64(), 10'd700);
    send_request(OP_SET,    rand64(), v,        rand64(), 10'd514);
    send_request(OP_ERASE,  rand64(), rand64(), rand64(), 10'd514);
    send_request(OP_REMOVE, 64'd102, rand64(), 64'd512, 10'd0);
    for (int c = 5; c < 8; c++)
      send_request(OP_W'(c), rand64(), rand64(), rand64(), SIDX_W'($urandom_range(1023)));
    send_request(OP_ERASE,  rand64(), rand64(), rand64(), 10'd0);
    send_request(OP_SET,    rand64(), '0,       rand64(), 10'd1023);
  endtask

  task automatic random_request();
    int            r;
    int            sel;
    int            idx;
    bit            have;
    logic [63:0]   k;
    logic [63:0]   h;
    logic [63:0]   v;
    logic [SIDX_W-1:0] s;
    have = known_keys.size() > 0;
    idx  = have ? $urandom_range(known_keys.size() - 1) : 0;
    r    = $urandom_range(99);
    sel  = $urandom_range(99);
    k    = rand64();
    h    = fresh_hash();
    v    = rand64();
    s    = SIDX_W'($urandom_range(1023));
    if (have && $urandom_range(99) < 70)
      s = SIDX_W'(known_hashes[idx][9:0] + $urandom_range(0, 7));
    if (r < 30) begin
      if (have && sel < 25) begin
        k = known_keys[idx];
        h = known_hashes[idx];
      end else begin
        if (have && sel < 40) begin
          h = known_hashes[idx];
        end else if (have && sel < 50) begin
          k = known_keys[idx];
          h = rand64();
          h[9:0] = known_hashes[idx][9:0];
        end
        remember(k, h);
      end
      send_request(OP_INSERT, k, v, h, s);
    end else if (r < 55) begin
      if (have && sel < 70) begin
        k = known_keys[idx];
        h = known_hashes[idx];
      end
      send_request(OP_FIND, k, v, h, s);
    end else if (r < 72) begin
      if (have && sel < 80) begin
        k = known_keys[idx];
        h = known_hashes[idx];
      end
      send_request(OP_REMOVE, k, v, h, s);
    end else if (r < 84) begin
      send_request(OP_ERASE, k, v, h, s);
    end else if (r < 96) begin
      send_request(OP_SET, k, v, h, s);
    end else begin
      send_request(OP_W'($urandom_range(5, 7)), k, v, h, s);
    end
  endtask

  task automatic full_table_requests();
    logic [63:0] h;
    for (int i = 0; i < SLOTS; i++) begin
      if (board.flags[i] != FLAG_USED) begin
        h = rand64();
        h[9:0] = 10'(i);
        send_request(OP_INSERT, rand64(), rand64(), h, SIDX_W'(i));
      end
    end
    send_request(OP_INSERT, rand64(), rand64(), fresh_hash(), 10'd0);
    send_request(OP_INSERT, known_keys[0], rand64(), known_hashes[0], 10'd0);
    send_request(OP_FIND,   rand64(), rand64(), fresh_hash(), 10'd0);
    send_request(OP_FIND,   known_keys[1], rand64(), known_hashes[1], 10'd0);
    send_request(OP_ERASE,  rand64(), rand64(), rand64(), 10'd0);
    send_request(OP_FIND,   rand64(), rand64(), fresh_hash(), 10'd0);
    send_request(OP_REMOVE, rand64(), rand64(), fresh_hash(), 10'd0);
    send_request(OP_INSERT, rand64(), rand64(), 64'd5, 10'd0);
    send_request(OP_INSERT, rand64(), rand64(), 64'd6, 10'd0);
  endtask

  initial begin
    board       = new;
    tx_idle_pct = 10;
    rx_idle_pct = 55;
    hold_left   = 0;
    hold_done   = 1'b0;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    op         <= OP_INSERT;
    key        <= '0;
    value      <= '0;
    key_hash   <= '0;
    slot_index <= '0;
    out_stall  <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_requests();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 55;
        rx_idle_pct = 10;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_request();
    end
    full_table_requests();
    in_valid <= 1'b0;

    while (board.due_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.due_responses.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
